@@ hw/rtl/ppp_pkg.sv @@
// Shared types, widths and constants for the panorama point projection.
// No dependencies; used by every ppp_* module and the top level.
package ppp_pkg;

  localparam int WIDTH_LIMIT  = 640;
  localparam int HEIGHT_LIMIT = 370;
  localparam int ANGLE_STAGES = 16;

  localparam int PW  = 36;  // camera point, Q16.16 kept wide
  localparam int CW  = 40;  // cordic x/y datapath
  localparam int AW  = 28;  // angle, Q.24 radians
  localparam int IW  = 5;   // cordic step index
  localparam int MLW = 19;  // radius multiply split point

  localparam logic signed [AW-1:0] PI_Q24      = AW'(52707179);
  localparam logic signed [AW-1:0] HALF_PI_Q24 = AW'(26353589);
  localparam logic signed [AW-1:0] TWO_PI_Q24  = AW'(105414357);
  localparam logic [15:0]          INV_GAIN    = 16'd39797;
  localparam logic signed [23:0]   PIX_MAX     = 24'sh7FFFFF;
  localparam logic signed [23:0]   PIX_MIN     = 24'sh800000;

  typedef enum logic [2:0] {
    REG_ROT0  = 3'd0,
    REG_ROT1  = 3'd1,
    REG_ROT2  = 3'd2,
    REG_SHX   = 3'd3,
    REG_SHY   = 3'd4,
    REG_SHZ   = 3'd5,
    REG_PPR   = 3'd6,
    REG_TOP   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic signed [CW-1:0] side;
  } cord_t;

  function automatic logic signed [AW-1:0] atan_q24(input logic [IW-1:0] i);
    logic signed [AW-1:0] v;
    unique case (i)
      5'd0:  v = AW'(13176795);
      5'd1:  v = AW'(7778716);
      5'd2:  v = AW'(4110060);
      5'd3:  v = AW'(2086331);
      5'd4:  v = AW'(1047214);
      5'd5:  v = AW'(524117);
      5'd6:  v = AW'(262123);
      5'd7:  v = AW'(131069);
      5'd8:  v = AW'(65536);
      5'd9:  v = AW'(32768);
      5'd10: v = AW'(16384);
      5'd11: v = AW'(8192);
      5'd12: v = AW'(4096);
      5'd13: v = AW'(2048);
      5'd14: v = AW'(1024);
      5'd15: v = AW'(512);
      5'd16: v = AW'(256);
      5'd17: v = AW'(128);
      5'd18: v = AW'(64);
      5'd19: v = AW'(32);
      5'd20: v = AW'(16);
      5'd21: v = AW'(8);
      5'd22: v = AW'(4);
      5'd23: v = AW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/ppp_rotate.sv @@
// Rigid transform pc = R*p + t, two stages: products, then sum/round/translate.
// Depends on ppp_pkg.
module ppp_rotate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [2:0][47:0]              rot_i,
  input  logic [2:0][31:0]              shift_i,
  input  logic [2:0][31:0]              pt_i,
  output logic                          vld_o,
  output logic [2:0][ppp_pkg::PW-1:0]   pc_o
);

  logic              vld1_q, vld2_q;
  logic signed [47:0] prod_d [3][3];
  logic signed [47:0] prod_q [3][3];
  logic [2:0][ppp_pkg::PW-1:0] pc_d, pc_q;
  logic signed [49:0] acc [3];
  logic signed [49:0] rnd [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(rot_i[r][16*c +: 16]) * $signed(pt_i[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 50'(prod_q[r][0]) + 50'(prod_q[r][1]) + 50'(prod_q[r][2]) + 50'sd8192;
      rnd[r] = (acc[r] >>> 14) + 50'($signed(shift_i[r]));
      pc_d[r] = rnd[r][ppp_pkg::PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      pc_q   <= pc_d;
    end
  end

  assign vld_o = vld2_q;
  assign pc_o  = pc_q;

endmodule

@@ hw/rtl/ppp_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation, registered.
// Depends on ppp_pkg (cord_t, atan_q24).
module ppp_cordic_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [ppp_pkg::IW-1:0]  idx_i,
  input  ppp_pkg::cord_t          cell_i,
  output ppp_pkg::cord_t          cell_o
);

  logic                 vld_q;
  ppp_pkg::cord_t       dat_d, dat_q;
  logic signed [ppp_pkg::CW-1:0] dx, dy;
  logic signed [ppp_pkg::AW-1:0] da;

  always_comb begin
    dx    = cell_i.y >>> idx_i;
    dy    = cell_i.x >>> idx_i;
    da    = ppp_pkg::atan_q24(idx_i);
    dat_d = cell_i;
    if (!cell_i.y[ppp_pkg::CW-1]) begin
      dat_d.x   = cell_i.x + dx;
      dat_d.y   = cell_i.y - dy;
      dat_d.ang = cell_i.ang + da;
    end else begin
      dat_d.x   = cell_i.x - dx;
      dat_d.y   = cell_i.y + dy;
      dat_d.ang = cell_i.ang - da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  always_comb begin
    cell_o     = dat_q;
    cell_o.vld = vld_q;
  end

endmodule

@@ hw/rtl/ppp_cordic.sv @@
// atan2 by a chain of CORDIC cells after a registered quadrant pre-rotation.
// Depends on ppp_pkg and ppp_cordic_cell.
module ppp_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic signed [ppp_pkg::CW-1:0]  x_i,
  input  logic signed [ppp_pkg::CW-1:0]  y_i,
  input  logic signed [ppp_pkg::CW-1:0]  side_i,
  output logic                           vld_o,
  output logic signed [ppp_pkg::AW-1:0]  ang_o,
  output logic signed [ppp_pkg::CW-1:0]  mag_o,
  output logic signed [ppp_pkg::CW-1:0]  side_o
);

  logic           vld_q;
  ppp_pkg::cord_t pre_d, pre_q, head;
  ppp_pkg::cord_t chain [ppp_pkg::ANGLE_STAGES+1];

  always_comb begin
    pre_d      = '0;
    pre_d.vld  = vld_i;
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.side = side_i;
    pre_d.x    = x_i;
    pre_d.y    = y_i;
    if (x_i[ppp_pkg::CW-1]) begin
      if (!y_i[ppp_pkg::CW-1]) begin
        pre_d.x   = y_i;
        pre_d.y   = -x_i;
        pre_d.ang = ppp_pkg::HALF_PI_Q24;
      end else begin
        pre_d.x   = -y_i;
        pre_d.y   = x_i;
        pre_d.ang = -ppp_pkg::HALF_PI_Q24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  always_comb begin
    head     = pre_q;
    head.vld = vld_q;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < ppp_pkg::ANGLE_STAGES; g++) begin : g_cell
    ppp_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .idx_i  (ppp_pkg::IW'(g)),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // atan2(0,0) is zero
  assign vld_o  = chain[ppp_pkg::ANGLE_STAGES].vld;
  assign ang_o  = chain[ppp_pkg::ANGLE_STAGES].zero ? '0 : chain[ppp_pkg::ANGLE_STAGES].ang;
  assign mag_o  = chain[ppp_pkg::ANGLE_STAGES].zero ? '0 : chain[ppp_pkg::ANGLE_STAGES].x;
  assign side_o = chain[ppp_pkg::ANGLE_STAGES].side;

endmodule

@@ hw/rtl/ppp_radius.sv @@
// Gain-corrected radius, longitude wrap and negated y between the two CORDICs.
// Two stages; depends on ppp_pkg.
module ppp_radius (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic signed [ppp_pkg::AW-1:0]  theta_i,
  input  logic signed [ppp_pkg::CW-1:0]  mag_i,
  input  logic signed [ppp_pkg::CW-1:0]  pcy_i,
  output logic                           vld_o,
  output logic signed [ppp_pkg::CW-1:0]  rad_o,
  output logic signed [ppp_pkg::CW-1:0]  ny_o,
  output logic signed [ppp_pkg::CW-1:0]  theta_o
);

  localparam int HW = ppp_pkg::CW - ppp_pkg::MLW;

  logic                           vld1_q, vld2_q;
  logic [ppp_pkg::MLW+15:0]       plo_q;
  logic [HW+15:0]                 phi_q;
  logic signed [ppp_pkg::CW-1:0]  ny1_q, ny2_q, th1_q, th2_q, rad_q;
  logic signed [ppp_pkg::AW-1:0]  th_w;
  logic [ppp_pkg::CW+15:0]        sum;

  always_comb begin
    th_w = theta_i;
    if (theta_i < -ppp_pkg::HALF_PI_Q24) begin
      th_w = theta_i + ppp_pkg::TWO_PI_Q24;
    end
  end

  assign sum = ((ppp_pkg::CW+16)'(phi_q) << ppp_pkg::MLW) + (ppp_pkg::CW+16)'(plo_q)
             + (ppp_pkg::CW+16)'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= mag_i[ppp_pkg::MLW-1:0] * ppp_pkg::INV_GAIN;
      phi_q <= mag_i[ppp_pkg::CW-1:ppp_pkg::MLW] * ppp_pkg::INV_GAIN;
      ny1_q <= -pcy_i;
      th1_q <= ppp_pkg::CW'(th_w);
      rad_q <= $signed(sum[ppp_pkg::CW+15:16]);
      ny2_q <= ny1_q;
      th2_q <= th1_q;
    end
  end

  assign vld_o   = vld2_q;
  assign rad_o   = rad_q;
  assign ny_o    = ny2_q;
  assign theta_o = th2_q;

endmodule

@@ hw/rtl/ppp_pixel.sv @@
// Angle to pixel scaling, crop offset, saturation and view test; three stages.
// Depends on ppp_pkg.
module ppp_pixel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic signed [ppp_pkg::AW-1:0]  theta_i,
  input  logic signed [ppp_pkg::AW-1:0]  phi_i,
  input  logic [17:0]                    ppr_i,
  input  logic [19:0]                    top_i,
  output logic                           vld_o,
  output logic signed [23:0]             col_o,
  output logic signed [23:0]             row_o,
  output logic                           view_o
);

  logic               vld1_q, vld2_q, vld3_q;
  logic signed [28:0] dc_q, dr_q;
  logic signed [47:0] pc_q, pr_q;
  logic signed [48:0] rc, rr;
  logic signed [25:0] vc, vr;
  logic signed [23:0] col_d, row_d, col_q, row_q;
  logic               view_d, view_q;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] s;
    if (v > 26'(ppp_pkg::PIX_MAX)) begin
      s = ppp_pkg::PIX_MAX;
    end else if (v < 26'(ppp_pkg::PIX_MIN)) begin
      s = ppp_pkg::PIX_MIN;
    end else begin
      s = v[23:0];
    end
    return s;
  endfunction

  always_comb begin
    rc     = 49'(pc_q) + 49'sd8388608;
    rr     = 49'(pr_q) + 49'sd8388608;
    vc     = 26'(rc >>> 24);
    vr     = 26'(rr >>> 24) - $signed({6'd0, top_i});
    col_d  = sat24(vc);
    row_d  = sat24(vr);
    view_d = !col_d[23] && (col_d <= 24'(ppp_pkg::WIDTH_LIMIT * 256))
          && !row_d[23] && (row_d <= 24'(ppp_pkg::HEIGHT_LIMIT * 256));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dc_q   <= 29'(ppp_pkg::PI_Q24) - 29'(theta_i);
      dr_q   <= 29'(ppp_pkg::HALF_PI_Q24) - 29'(phi_i);
      pc_q   <= 48'(dc_q * $signed({1'b0, ppr_i}));
      pr_q   <= 48'(dr_q * $signed({1'b0, ppr_i}));
      col_q  <= col_d;
      row_q  <= row_d;
      view_q <= view_d;
    end
  end

  assign vld_o  = vld3_q;
  assign col_o  = col_q;
  assign row_o  = row_q;
  assign view_o = view_q;

endmodule

@@ hw/rtl/panorama_point_projection.sv @@
// Top level of the panorama point projection: config registers and pipeline.
// Depends on ppp_pkg, ppp_rotate, ppp_cordic, ppp_radius, ppp_pixel.
//
// Fully pipelined: one point per cycle while the output is not stalled, through
// ppp_rotate, two chains of 16 CORDIC cells with ppp_radius between them, and
// ppp_pixel. The whole pipeline advances when the output register is empty or
// being taken, so a stalled output holds every stage. Write configuration
// only while the pipeline is empty; the cfg channel is always ready.
module panorama_point_projection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // point_x, point_y, point_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // pixel_col, pixel_row
  output logic        m_axis_tuser_o,   // in_view
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [2:0][47:0] rot_q;
  logic [2:0][31:0] shift_q;
  logic [17:0]      ppr_q;
  logic [19:0]      top_q;
  logic             en;

  logic                          rot_vld;
  logic [2:0][ppp_pkg::PW-1:0]   pc;
  logic                          lon_vld, rad_vld, lat_vld, out_vld;
  logic signed [ppp_pkg::AW-1:0] theta, phi;
  logic signed [ppp_pkg::CW-1:0] lon_mag, lon_side, rad, ny, th_side, lat_mag, lat_side;
  logic signed [23:0]            col, row;
  logic                          view;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= 48'd16384;
      rot_q[1]   <= 48'd16384 << 16;
      rot_q[2]   <= 48'd16384 << 32;
      shift_q    <= '0;
      ppr_q      <= 18'd26075;
      top_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (ppp_pkg::reg_idx_e'(cfg_index_i))
        ppp_pkg::REG_ROT0: rot_q[0]   <= cfg_data_i;
        ppp_pkg::REG_ROT1: rot_q[1]   <= cfg_data_i;
        ppp_pkg::REG_ROT2: rot_q[2]   <= cfg_data_i;
        ppp_pkg::REG_SHX:  shift_q[0] <= cfg_data_i[31:0];
        ppp_pkg::REG_SHY:  shift_q[1] <= cfg_data_i[31:0];
        ppp_pkg::REG_SHZ:  shift_q[2] <= cfg_data_i[31:0];
        ppp_pkg::REG_PPR:  ppr_q      <= cfg_data_i[17:0];
        ppp_pkg::REG_TOP:  top_q      <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  assign en              = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ppp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_axis_tvalid_i),
    .rot_i   (rot_q),
    .shift_i (shift_q),
    .pt_i    ({s_axis_tdata_i[95:64], s_axis_tdata_i[63:32], s_axis_tdata_i[31:0]}),
    .vld_o   (rot_vld),
    .pc_o    (pc)
  );

  ppp_cordic u_lon (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rot_vld),
    .x_i    (ppp_pkg::CW'($signed(pc[0]))),
    .y_i    (ppp_pkg::CW'($signed(pc[2]))),
    .side_i (ppp_pkg::CW'($signed(pc[1]))),
    .vld_o  (lon_vld),
    .ang_o  (theta),
    .mag_o  (lon_mag),
    .side_o (lon_side)
  );

  ppp_radius u_radius (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (lon_vld),
    .theta_i (theta),
    .mag_i   (lon_mag),
    .pcy_i   (lon_side),
    .vld_o   (rad_vld),
    .rad_o   (rad),
    .ny_o    (ny),
    .theta_o (th_side)
  );

  ppp_cordic u_lat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rad_vld),
    .x_i    (rad),
    .y_i    (ny),
    .side_i (th_side),
    .vld_o  (lat_vld),
    .ang_o  (phi),
    .mag_o  (lat_mag),
    .side_o (lat_side)
  );

  ppp_pixel u_pixel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (lat_vld),
    .theta_i (lat_side[ppp_pkg::AW-1:0]),
    .phi_i   (phi),
    .ppr_i   (ppr_q),
    .top_i   (top_q),
    .vld_o   (out_vld),
    .col_o   (col),
    .row_o   (row),
    .view_o  (view)
  );

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {row, col};
  assign m_axis_tuser_o  = view & ~(|lat_mag[0]) | view & lat_mag[0];

endmodule

@@ verif/panorama_point_projection_tb.sv @@
// Testbench for panorama_point_projection: a bit-exact projection predictor,
// directed and random point streams, random stalls on both streams and cfg writes.
// Depends on ppp_pkg and the panorama_point_projection RTL.
`timescale 1ns / 1ps

module panorama_point_projection_tb;
  import ppp_pkg::*;

  localparam int LATENCY   = 41;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    logic signed [23:0] col;
    logic signed [23:0] row;
    logic               view;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  panorama_point_projection uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the registers
  logic [47:0]        rot_q [3];
  logic signed [31:0] shift_q [3];
  logic [17:0]        ppr_q;
  logic [19:0]        top_q;

  pixel_t pixel_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     rx_stall_en = 1'b1;
  bit     tx_gap_en = 1'b1;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = HALF_PI_Q24;
      end else begin
        x = -y; y = t; ang = -HALF_PI_Q24;
      end
    end
    for (int i = 0; i < ANGLE_STAGES; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; ang += longint'(atan_q24(IW'(i)));
      end else begin
        x -= dx; y += dy; ang -= longint'(atan_q24(IW'(i)));
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic pixel_t project_point(logic [95:0] pt);
    longint p[3], pc[3], acc, theta, phi, mag, rad, col, row;
    pixel_t r;
    for (int c = 0; c < 3; c++) p[c] = longint'($signed(pt[32*c +: 32]));
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += longint'($signed(rot_q[k][16*c +: 16])) * p[c];
      pc[k] = round_shr(acc, 14) + longint'(shift_q[k]);
    end
    theta = vector_angle(pc[0], pc[2], mag);
    if (theta < -longint'(HALF_PI_Q24)) theta += TWO_PI_Q24;
    rad = round_shr(mag * 39797, 16);
    phi = vector_angle(rad, -pc[1], mag);
    col = sat24(round_shr((longint'(PI_Q24) - theta) * longint'(ppr_q), 24));
    row = sat24(round_shr((longint'(HALF_PI_Q24) - phi) * longint'(ppr_q), 24)
                - longint'(top_q));
    r.col = col[23:0];
    r.row = row[23:0];
    r.view = col >= 0 && col <= WIDTH_LIMIT * 256 && row >= 0 && row <= HEIGHT_LIMIT * 256;
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ROT0, REG_ROT1, REG_ROT2: rot_q[idx] = val;
      REG_SHX, REG_SHY, REG_SHZ:    shift_q[idx - REG_SHX] = val[31:0];
      REG_PPR:                      ppr_q = val[17:0];
      default:                      top_q = val[19:0];
    endcase
    @(posedge clk_i);
  endtask

  // tvalid stays high between back-to-back requests; drain() drops it
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (tx_gap_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixel_q.insert(pixel_q.size(), project_point({z, y, x}));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return 32'($signed($urandom_range(0, 2 * 65536 * 50)) - 65536 * 50);
    endcase
  endfunction

  function automatic logic [47:0] rand_rot_row();
    logic [47:0] v;
    for (int c = 0; c < 3; c++)
      v[16*c +: 16] = $urandom_range(0, 3) == 0 ? 16'($urandom())
                                                : 16'($signed($urandom_range(0, 32768)) - 16384);
    return v;
  endfunction

  task automatic test_identity_points();
    send_point(0, 0, 0);
    send_point(32'h0001_0000, 0, 0);
    send_point(32'hFFFF_0000, 0, 0);
    send_point(0, 0, 32'h0001_0000);
    send_point(0, 0, 32'hFFFF_0000);
    send_point(32'hFFFF_0000, 0, 32'hFFFF_0000);
    send_point(32'hFFFF_0000, 0, 32'h0000_0001);
    send_point(0, 32'h0001_0000, 0);
    send_point(0, 32'hFFFF_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_ROT0, 48'h8000_7FFF_FFFF);
    write_reg(REG_ROT1, 48'h7FFF_8000_0001);
    write_reg(REG_ROT2, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_SHX, 48'h7FFF_FFFF);
    write_reg(REG_SHY, 48'h8000_0000);
    write_reg(REG_SHZ, 48'hFFFF_FFFF);
    write_reg(REG_PPR, 48'h3FFFF);
    write_reg(REG_TOP, 48'hFFFFF);
    send_point(0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(REG_PPR, 48'h0);
    write_reg(REG_TOP, 48'h0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    drain();
  endtask

  task automatic test_random_phase(int n, bit rand_cfg);
    if (rand_cfg) begin
      write_reg(REG_ROT0, rand_rot_row());
      write_reg(REG_ROT1, rand_rot_row());
      write_reg(REG_ROT2, rand_rot_row());
      write_reg(REG_SHX, {16'h0, rand_coord()});
      write_reg(REG_SHY, {16'h0, rand_coord()});
      write_reg(REG_SHZ, {16'h0, rand_coord()});
      write_reg(REG_PPR, $urandom_range(0, 3) == 0 ? 48'($urandom()) : 48'($urandom_range(20000, 30000)));
      write_reg(REG_TOP, $urandom_range(0, 3) == 0 ? 48'($urandom()) : 48'($urandom_range(0, 8000)));
    end
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    rot_q[0] = 48'h4000; rot_q[1] = 48'h4000 << 16; rot_q[2] = 48'h4000 << 32;
    foreach (shift_q[k]) shift_q[k] = 0;
    ppr_q = 18'd26075;
    top_q = 20'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_points();
    test_random_phase(150, 1'b0);
    test_register_extremes();
    for (int ph = 0; ph < 4; ph++) test_random_phase(150, 1'b1);
    write_reg(REG_ROT0, 48'h4000);
    write_reg(REG_ROT1, 48'h4000 << 16);
    write_reg(REG_ROT2, 48'h4000 << 32);
    write_reg(REG_SHX, 48'h0);
    write_reg(REG_SHY, 48'h0);
    write_reg(REG_SHZ, 48'h0);
    write_reg(REG_PPR, 48'd26075);
    write_reg(REG_TOP, 48'd0);
    test_random_phase(100, 1'b0);
    tx_gap_en = 1'b0;
    rx_stall_en = 1'b0;
    test_random_phase(100, 1'b1);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // output side: random stall bursts, then compare each result
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %b", m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          pixel_t e;
          e = pixel_q.pop_front();
          if (m_axis_tdata_o[23:0] !== e.col || m_axis_tdata_o[47:24] !== e.row ||
              m_axis_tuser_o !== e.view) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp col %h row %h view %b, got col %h row %h view %b",
                       e.col, e.row, e.view, m_axis_tdata_o[23:0], m_axis_tdata_o[47:24],
                       m_axis_tuser_o);
          end
        end
      end
      if (stall > 0) stall--;
      else if (rx_stall_en && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 15);
      m_axis_tready_i <= (stall == 0);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
